[rtl/clipped_raster_draw_engine_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the clipped raster draw engine
// Each macro wraps one concurrent assertion and is empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_RASTER_DRAW_ENGINE_ASSERT_SVH
`define CLIPPED_RASTER_DRAW_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CRDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("clipped_raster_draw_engine: assertion failed");
// Next-cycle implication.
`define CRDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("clipped_raster_draw_engine: assertion failed");
`else
`define CRDE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CRDE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/crde_pkg.sv]
// ----------------------------------------------------------------------------
// crde_pkg
// Types and constants shared by the draw engine's front end, queue and back end.
// ----------------------------------------------------------------------------
package crde_pkg;

	// Clipped coordinates; the screen is at most 1024 pixels on either axis.
	localparam int CRD_W = 10;
	// Signed width for unclipped coordinates and their sums.
	localparam int CLIP_W = 18;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OUTLINE_LAST_SPAN = 2'd3;

	typedef enum logic [2:0] {
		ACT_PLOT    = 3'd0,
		ACT_READ    = 3'd1,
		ACT_HSPAN   = 3'd2,
		ACT_VSPAN   = 3'd3,
		ACT_OUTLINE = 3'd4,
		ACT_FILL    = 3'd5,
		ACT_CLEAR   = 3'd6,
		ACT_NOP     = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_FILL,
		JOB_READ
	} job_kind_t;

	// One clipped rectangle (inclusive bounds) or one pixel read.
	typedef struct packed {
		job_kind_t        kind;
		logic             last;
		logic [CRD_W-1:0] col_lo;
		logic [CRD_W-1:0] col_hi;
		logic [CRD_W-1:0] row_lo;
		logic [CRD_W-1:0] row_hi;
		logic [7:0]       color;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [2:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_SETUP,
		BK_FILL,
		BK_READ,
		BK_RDATA
	} back_state_t;

endpackage

[rtl/crde_fifo.sv]
// ----------------------------------------------------------------------------
// crde_fifo
// Short job queue between the command front end and the pixel back end.
// ----------------------------------------------------------------------------
module crde_fifo
	import crde_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  job_t          push_job,
	input  logic          pop,
	output job_t          pop_job,
	output queue_status_t status
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign pop_job      = slot_q[rd_ptr_q];
	assign status.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

[rtl/crde_front.sv]
// ----------------------------------------------------------------------------
// crde_front
// Takes a command, clips it to the screen and queues one or more jobs.
// ----------------------------------------------------------------------------
module crde_front
	import crde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [2:0]         action,
	input  logic signed [15:0] x_pos,
	input  logic signed [15:0] y_pos,
	input  logic signed [15:0] extent_w,
	input  logic signed [15:0] extent_h,
	input  logic [7:0]         pixel_color,
	input  queue_status_t      qs,
	output logic               busy,
	output logic               push,
	output job_t               push_job
);

	localparam logic signed [CLIP_W-1:0] SCR_W_S = CLIP_W'(SCREEN_WIDTH);
	localparam logic signed [CLIP_W-1:0] SCR_H_S = CLIP_W'(SCREEN_HEIGHT);
	localparam logic signed [CLIP_W-1:0] ONE_S   = CLIP_W'(1);

	logic                     active_q;
	logic [1:0]               step_q;
	action_t                  act_q;
	logic [7:0]               color_q;
	logic signed [CLIP_W-1:0] x_q, x1_q, xe_q, xe1_q;
	logic signed [CLIP_W-1:0] y_q, y1_q, ye_q, ye1_q;

	logic signed [CLIP_W-1:0] cs, ce, rs, re;
	logic signed [CLIP_W-1:0] col_lo_s, col_hx_s, row_lo_s, row_hx_s;
	logic signed [CLIP_W-1:0] col_hi_s, row_hi_s;
	logic                     col_ok, row_ok, last_step;
	job_kind_t                kind;

	// Sums are formed once when the command is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action_t'(action);
			color_q <= pixel_color;
			x_q     <= CLIP_W'(x_pos);
			x1_q    <= CLIP_W'(x_pos) + ONE_S;
			xe_q    <= CLIP_W'(x_pos) + CLIP_W'(extent_w);
			xe1_q   <= CLIP_W'(x_pos) + CLIP_W'(extent_w) - ONE_S;
			y_q     <= CLIP_W'(y_pos);
			y1_q    <= CLIP_W'(y_pos) + ONE_S;
			ye_q    <= CLIP_W'(y_pos) + CLIP_W'(extent_h);
			ye1_q   <= CLIP_W'(y_pos) + CLIP_W'(extent_h) - ONE_S;
		end
	end

	// Each job is a half-open column range and row range before clipping.
	always_comb begin
		cs        = x_q;
		ce        = x1_q;
		rs        = y_q;
		re        = y1_q;
		kind      = JOB_FILL;
		last_step = 1'b1;
		case (act_q)
			ACT_PLOT: begin
			end
			ACT_READ: begin
				kind = JOB_READ;
			end
			ACT_HSPAN: begin
				ce = xe_q;
			end
			ACT_VSPAN: begin
				re = ye_q;
			end
			ACT_OUTLINE: begin
				last_step = (step_q == OUTLINE_LAST_SPAN);
				case (step_q)
					2'd0: begin
						ce = xe_q;
					end
					2'd1: begin
						ce = xe_q;
						rs = ye1_q;
						re = ye_q;
					end
					2'd2: begin
						re = ye_q;
					end
					default: begin
						cs = xe1_q;
						ce = xe_q;
						re = ye_q;
					end
				endcase
			end
			ACT_FILL: begin
				ce = xe_q;
				re = ye_q;
			end
			ACT_CLEAR: begin
				cs = '0;
				ce = SCR_W_S;
				rs = '0;
				re = SCR_H_S;
			end
			default: begin
				kind = JOB_NONE;
			end
		endcase

		col_lo_s = cs[CLIP_W-1] ? '0 : cs;
		col_hx_s = (ce > SCR_W_S) ? SCR_W_S : ce;
		row_lo_s = rs[CLIP_W-1] ? '0 : rs;
		row_hx_s = (re > SCR_H_S) ? SCR_H_S : re;
		col_ok   = (col_lo_s < col_hx_s);
		row_ok   = (row_lo_s < row_hx_s);
		col_hi_s = col_hx_s - ONE_S;
		row_hi_s = row_hx_s - ONE_S;

		push_job.kind   = (col_ok && row_ok) ? kind : JOB_NONE;
		push_job.last   = last_step;
		push_job.col_lo = col_lo_s[CRD_W-1:0];
		push_job.col_hi = col_hi_s[CRD_W-1:0];
		push_job.row_lo = row_lo_s[CRD_W-1:0];
		push_job.row_hi = row_hi_s[CRD_W-1:0];
		push_job.color  = color_q;
	end

	assign push = active_q && !qs.full;
	assign busy = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			step_q   <= '0;
		end else if (push) begin
			if (last_step) begin
				active_q <= 1'b0;
			end
			step_q <= step_q + 1'b1;
		end
	end

endmodule

[rtl/crde_back.sv]
// ----------------------------------------------------------------------------
// crde_back
// Owns the frame store: clears it after reset, fills clipped rectangles one
// pixel per cycle and serves pixel reads.
// ----------------------------------------------------------------------------
module crde_back
	import crde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t qs,
	input  job_t          job,
	output logic          pop,
	output logic          sweeping,
	output logic          done,
	output logic [7:0]    pixel_value,
	output logic          in_bounds
);

	localparam int                DEPTH     = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int                ADDR_W    = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);

	logic [7:0]        store_mem [DEPTH];

	back_state_t       state_q, state_d;
	job_t              job_q;
	logic [CRD_W-1:0]  col_q, row_q;
	logic [ADDR_W-1:0] base_q, sweep_q;
	logic [7:0]        rdata_q;
	logic              done_q, in_bounds_q;
	logic [7:0]        pixel_q;

	logic              wr_en, rd_en, emit, emit_read;
	logic [ADDR_W-1:0] wr_addr, pix_addr;
	logic [7:0]        wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		emit      = 1'b0;
		emit_read = 1'b0;
		pix_addr  = base_q + ADDR_W'(col_q);
		wr_addr   = pix_addr;
		wr_data   = job_q.color;
		case (state_q)
			BK_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
				if (sweep_q == LAST_ADDR) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!qs.empty) begin
					pop = 1'b1;
					case (job.kind)
						JOB_FILL, JOB_READ: begin
							state_d = BK_SETUP;
						end
						default: begin
							// Nothing on screen: only the last job of a command reports.
							emit = job.last;
						end
					endcase
				end
			end
			BK_SETUP: begin
				state_d = (job_q.kind == JOB_READ) ? BK_READ : BK_FILL;
			end
			BK_FILL: begin
				wr_en = 1'b1;
				if (col_q == job_q.col_hi && row_q == job_q.row_hi) begin
					emit    = job_q.last;
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_RDATA;
			end
			BK_RDATA: begin
				emit      = 1'b1;
				emit_read = 1'b1;
				state_d   = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= store_mem[pix_addr];
		end
	end

	// Walk the rectangle row by row, keeping the row's base address.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				job_q <= job;
			end
			BK_SETUP: begin
				base_q <= ADDR_W'(job_q.row_lo) * ROW_STEP;
				col_q  <= job_q.col_lo;
				row_q  <= job_q.row_lo;
			end
			BK_FILL: begin
				if (col_q == job_q.col_hi) begin
					col_q  <= job_q.col_lo;
					row_q  <= row_q + 1'b1;
					base_q <= base_q + ROW_STEP;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			done_q      <= 1'b0;
			pixel_q     <= '0;
			in_bounds_q <= 1'b0;
		end else begin
			if (state_q == BK_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			done_q      <= emit;
			pixel_q     <= emit_read ? rdata_q : '0;
			in_bounds_q <= emit_read;
		end
	end

	assign sweeping    = (state_q == BK_SWEEP);
	assign done        = done_q;
	assign pixel_value = pixel_q;
	assign in_bounds   = in_bounds_q;

endmodule

[rtl/clipped_raster_draw_engine.sv]
// ----------------------------------------------------------------------------
// clipped_raster_draw_engine
// Byte-per-pixel drawing engine with screen clipping over an on-chip frame store.
// ----------------------------------------------------------------------------
// After reset the frame store is swept to zero, one pixel a cycle; busy stays
// high throughout. A command is taken when start is high and busy is low, and
// the front end then queues its jobs (four for an outline, one for everything
// else), holding while the queue is full, before it takes another. The back end
// writes one pixel per cycle through the frame store's write port. It pops each
// job in its idle state; a job that lands on screen passes a setup state and
// then fills its clipped span or rectangle, or reads its pixel. Exactly one
// result follows each command, in command order, as a single-cycle done pulse
// with pixel_value and in_bounds; there is no way to hold it off, so it must be
// captured on that edge.
// ----------------------------------------------------------------------------
`include "clipped_raster_draw_engine_assert.svh"

module clipped_raster_draw_engine
	import crde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [15:0] x_pos,
	input  logic signed [15:0] y_pos,
	input  logic signed [15:0] extent_w,
	input  logic signed [15:0] extent_h,
	input  logic [7:0]         pixel_color,
	output logic               done,
	output logic [7:0]         pixel_value,
	output logic               in_bounds
);

	logic          accept;
	logic          front_busy;
	logic          sweeping;
	logic          q_push, q_pop;
	job_t          push_job, pop_job;
	queue_status_t qs;

	assign busy   = front_busy || sweeping;
	assign accept = start && !busy;

	crde_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.extent_w   (extent_w),
		.extent_h   (extent_h),
		.pixel_color(pixel_color),
		.qs         (qs),
		.busy       (front_busy),
		.push       (q_push),
		.push_job   (push_job)
	);

	crde_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.pop     (q_pop),
		.pop_job (pop_job),
		.status  (qs)
	);

	crde_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qs         (qs),
		.job        (pop_job),
		.pop        (q_pop),
		.sweeping   (sweeping),
		.done       (done),
		.pixel_value(pixel_value),
		.in_bounds  (in_bounds)
	);

	`CRDE_ASSERT_IMP(a_no_result_while_sweeping, clk, arst_n, sweeping, !done)
	`CRDE_ASSERT_IMP(a_quiet_result_bus, clk, arst_n, !done, !in_bounds && pixel_value == '0)
	`CRDE_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, busy)
	`CRDE_ASSERT_IMP(a_push_has_room, clk, arst_n, q_push, !qs.full)

endmodule
